### rtl/core/cdw_pkg.sv
// ----------------------------------------------------------------------------
// Code point display width package
// Shared widths, width codes and the East Asian ambiguous range table.
// ----------------------------------------------------------------------------
package cdw_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned WidthW = 2;

  // Stream data widths, padded up to whole bytes.
  localparam int unsigned SDataW = ((CpW + 7) / 8) * 8;
  localparam int unsigned MDataW = ((WidthW + 7) / 8) * 8;

  typedef logic [CpW-1:0]    cp_t;
  typedef logic [WidthW-1:0] cell_width_t;

  localparam cell_width_t WidthZero   = 2'd0;
  localparam cell_width_t WidthNarrow = 2'd1;
  localparam cell_width_t WidthWide   = 2'd2;

  localparam int unsigned AmbCount = 168;

  localparam cp_t AmbLo [AmbCount] = '{
    21'h00a1, 21'h00a4, 21'h00a7, 21'h00aa, 21'h00ad, 21'h00b0, 21'h00b6, 21'h00bc,
    21'h00c6, 21'h00d0, 21'h00d7, 21'h00de, 21'h00e6, 21'h00e8, 21'h00ec, 21'h00f0,
    21'h00f2, 21'h00f7, 21'h00fc, 21'h00fe, 21'h0101, 21'h0111, 21'h0113, 21'h011b,
    21'h0126, 21'h012b, 21'h0131, 21'h0138, 21'h013f, 21'h0144, 21'h0148, 21'h014d,
    21'h0152, 21'h0166, 21'h016b, 21'h01ce, 21'h01d0, 21'h01d2, 21'h01d4, 21'h01d6,
    21'h01d8, 21'h01da, 21'h01dc, 21'h0251, 21'h0261, 21'h02c4, 21'h02c7, 21'h02c9,
    21'h02cd, 21'h02d0, 21'h02d8, 21'h02dd, 21'h02df, 21'h0391, 21'h03a3, 21'h03b1,
    21'h03c3, 21'h0401, 21'h0410, 21'h0451, 21'h2010, 21'h2013, 21'h2018, 21'h201c,
    21'h2020, 21'h2024, 21'h2030, 21'h2032, 21'h2035, 21'h203b, 21'h203e, 21'h2074,
    21'h207f, 21'h2081, 21'h20ac, 21'h2103, 21'h2105, 21'h2109, 21'h2113, 21'h2116,
    21'h2121, 21'h2126, 21'h212b, 21'h2153, 21'h215b, 21'h2160, 21'h2170, 21'h2189,
    21'h2190, 21'h21b8, 21'h21d2, 21'h21d4, 21'h21e7, 21'h2200, 21'h2202, 21'h2207,
    21'h220b, 21'h220f, 21'h2211, 21'h2215, 21'h221a, 21'h221d, 21'h2223, 21'h2225,
    21'h2227, 21'h222e, 21'h2234, 21'h223c, 21'h2248, 21'h224c, 21'h2252, 21'h2260,
    21'h2264, 21'h226a, 21'h226e, 21'h2282, 21'h2286, 21'h2295, 21'h2299, 21'h22a5,
    21'h22bf, 21'h2312, 21'h2460, 21'h24eb, 21'h2550, 21'h2580, 21'h2592, 21'h25a0,
    21'h25a3, 21'h25b2, 21'h25b6, 21'h25bc, 21'h25c0, 21'h25c6, 21'h25cb, 21'h25ce,
    21'h25e2, 21'h25ef, 21'h2605, 21'h2609, 21'h260e, 21'h261c, 21'h261e, 21'h2640,
    21'h2642, 21'h2660, 21'h2663, 21'h2667, 21'h266c, 21'h266f, 21'h269e, 21'h26bf,
    21'h26c6, 21'h26cf, 21'h26d5, 21'h26e3, 21'h26e8, 21'h26eb, 21'h26f4, 21'h26f6,
    21'h26fb, 21'h26fe, 21'h273d, 21'h2776, 21'h2b56, 21'h3248, 21'he000, 21'hfffd
  };

  localparam cp_t AmbHi [AmbCount] = '{
    21'h00a1, 21'h00a4, 21'h00a8, 21'h00aa, 21'h00ae, 21'h00b4, 21'h00ba, 21'h00bf,
    21'h00c6, 21'h00d0, 21'h00d8, 21'h00e1, 21'h00e6, 21'h00ea, 21'h00ed, 21'h00f0,
    21'h00f3, 21'h00fa, 21'h00fc, 21'h00fe, 21'h0101, 21'h0111, 21'h0113, 21'h011b,
    21'h0127, 21'h012b, 21'h0133, 21'h0138, 21'h0142, 21'h0144, 21'h014b, 21'h014d,
    21'h0153, 21'h0167, 21'h016b, 21'h01ce, 21'h01d0, 21'h01d2, 21'h01d4, 21'h01d6,
    21'h01d8, 21'h01da, 21'h01dc, 21'h0251, 21'h0261, 21'h02c4, 21'h02c7, 21'h02cb,
    21'h02cd, 21'h02d0, 21'h02db, 21'h02dd, 21'h02df, 21'h03a1, 21'h03a9, 21'h03c1,
    21'h03c9, 21'h0401, 21'h044f, 21'h0451, 21'h2010, 21'h2016, 21'h2019, 21'h201d,
    21'h2022, 21'h2027, 21'h2030, 21'h2033, 21'h2035, 21'h203b, 21'h203e, 21'h2074,
    21'h207f, 21'h2084, 21'h20ac, 21'h2103, 21'h2105, 21'h2109, 21'h2113, 21'h2116,
    21'h2122, 21'h2126, 21'h212b, 21'h2154, 21'h215e, 21'h216b, 21'h2179, 21'h2189,
    21'h2199, 21'h21b9, 21'h21d2, 21'h21d4, 21'h21e7, 21'h2200, 21'h2203, 21'h2208,
    21'h220b, 21'h220f, 21'h2211, 21'h2215, 21'h221a, 21'h2220, 21'h2223, 21'h2225,
    21'h222c, 21'h222e, 21'h2237, 21'h223d, 21'h2248, 21'h224c, 21'h2252, 21'h2261,
    21'h2267, 21'h226b, 21'h226f, 21'h2283, 21'h2287, 21'h2295, 21'h2299, 21'h22a5,
    21'h22bf, 21'h2312, 21'h24e9, 21'h254b, 21'h2573, 21'h258f, 21'h2595, 21'h25a1,
    21'h25a9, 21'h25b3, 21'h25b7, 21'h25bd, 21'h25c1, 21'h25c8, 21'h25cb, 21'h25d1,
    21'h25e5, 21'h25ef, 21'h2606, 21'h2609, 21'h260f, 21'h261c, 21'h261e, 21'h2640,
    21'h2642, 21'h2661, 21'h2665, 21'h266a, 21'h266d, 21'h266f, 21'h269f, 21'h26bf,
    21'h26cd, 21'h26d3, 21'h26e1, 21'h26e3, 21'h26e9, 21'h26f1, 21'h26f4, 21'h26f9,
    21'h26fc, 21'h26ff, 21'h273d, 21'h277f, 21'h2b59, 21'h324f, 21'hf8ff, 21'hfffd
  };

endpackage

### rtl/core/codepoint_display_width_core.sv
// ----------------------------------------------------------------------------
// Code point display width core
// Classifies one Unicode code point per transfer into 0, 1 or 2 terminal cells.
// ----------------------------------------------------------------------------

// One code point is taken in every cycle unless the output stalls. Its cell
// width is offered on the output from the result register: the input transfer
// captures the code point in the input register, and the range compares of
// the classifier run between that register and the result register. A full
// stall on the output fills both registers, after which the input side waits
// for the output to drain. The ambiguous-wide mode is written over the config
// channel, which is always ready; it should only change while no code point is
// in flight. Code points above U+10FFFF are reported as narrow.
module codepoint_display_width_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel: bit 0 is the ambiguous-wide mode.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [cdw_pkg::SDataW-1:0]  s_axis_tdata_i,   // [20:0] code_point
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [cdw_pkg::MDataW-1:0]  m_axis_tdata_o    // [1:0] cell_width
);
  import cdw_pkg::*;

  logic        amb_q;
  logic        in_valid_q;
  cp_t         cp_q;
  logic        out_valid_q;
  cell_width_t width_q;
  cell_width_t width_d;
  logic        in_load;
  logic        out_load;
  logic        in_ready;
  logic        out_ready;

  function automatic logic in_span(cp_t c, cp_t lo, cp_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic cell_width_t classify(cp_t c, logic amb);
    logic zero_ctl;
    logic zero_mark;
    logic wide;
    logic ambiguous;
    zero_ctl  = (c < 21'h20) || in_span(c, 21'h7f, 21'h9f);
    zero_mark = in_span(c, 21'h0300, 21'h036f) || in_span(c, 21'h1ab0, 21'h1aff) ||
                in_span(c, 21'h1dc0, 21'h1dff) || in_span(c, 21'h20d0, 21'h20ff) ||
                in_span(c, 21'hfe20, 21'hfe2f);
    wide      = in_span(c, 21'h1100, 21'h115f) || (c == 21'h2329) || (c == 21'h232a) ||
                (in_span(c, 21'h2e80, 21'ha4cf) && (c != 21'h303f)) ||
                in_span(c, 21'hac00, 21'hd7a3) || in_span(c, 21'hf900, 21'hfaff) ||
                in_span(c, 21'hfe10, 21'hfe19) || in_span(c, 21'hfe30, 21'hfe6f) ||
                in_span(c, 21'hff00, 21'hff60) || in_span(c, 21'hffe0, 21'hffe6) ||
                in_span(c, 21'h1f300, 21'h1f64f) || in_span(c, 21'h1f900, 21'h1f9ff);
    ambiguous = 1'b0;
    for (int unsigned i = 0; i < AmbCount; i++) begin
      ambiguous = ambiguous | in_span(c, AmbLo[i], AmbHi[i]);
    end
    if (zero_ctl || zero_mark) begin
      return WidthZero;
    end else if (wide || (amb && ambiguous)) begin
      return WidthWide;
    end
    return WidthNarrow;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Each register takes a new item whenever it is empty or its content moves on.
  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign out_load  = in_valid_q && out_ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_load   = s_axis_tvalid_i && in_ready;

  assign width_d = classify(cp_q, amb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q       <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        amb_q <= cfg_data_i;
      end
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cp_q <= s_axis_tdata_i[CpW-1:0];
    end
    if (out_load) begin
      width_q <= width_d;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(MDataW - WidthW){1'b0}}, width_q};

`ifndef SYNTHESIS
  a_width_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (width_q == WidthZero || width_q == WidthNarrow ||
                     width_q == WidthWide))
    else $error("cell width holds an illegal code");

  a_control_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (cp_q < 21'h20)) |=> (width_q == WidthZero))
    else $error("control character not reported as zero width");

  a_cjk_wide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && in_span(cp_q, 21'hac00, 21'hd7a3)) |=> (width_q == WidthWide))
    else $error("Hangul syllable not reported as wide");

  a_drain_on_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(m_axis_tready_i))
    else $error("result dropped without an output transfer");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while both registers are full");
`endif

endmodule
